>>> design/nelj_pkg.sv
// Package for nested_edge_list_to_json: character codes, front-end phases,
// verdict codes and the command record passed from front end to back end.
// No dependencies.
`default_nettype none
package nelj_pkg;

	localparam int unsigned MAX_DEPTH_DEF = 15;
	localparam int unsigned CMD_BYTES     = 6;
	localparam int unsigned CQ_DEPTH      = 4;
	localparam int unsigned CQ_AW         = $clog2(CQ_DEPTH);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [2:0] {
		PH_START,
		PH_EXPECT,
		PH_KEY,
		PH_AFTER,
		PH_SKIP
	} ph_t;

	typedef enum logic [1:0] {
		ST_RUN = 2'd0,
		ST_ACC = 2'd1,
		ST_REJ = 2'd2
	} st_t;

	// n bytes to emit; fin marks the final byte as closing with that verdict
	typedef struct packed {
		logic [2:0]                  n;
		logic [CMD_BYTES-1:0][7:0]   b;
		st_t                         fin;
	} cmd_t;

	localparam cmd_t CMD_NONE = '{n: 3'd0, b: '0, fin: ST_RUN};

	function automatic cmd_t cmd_add(cmd_t c, logic [7:0] ch);
		cmd_t r;
		r = c;
		r.b[r.n] = ch;
		r.n = r.n + 3'd1;
		return r;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_USCORE;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage
`default_nettype wire

>>> design/nested_edge_list_to_json.sv
// Top level of nested_edge_list_to_json: front end, command queue, back end.
// Uses nelj_pkg, nelj_front, nelj_cmdq, nelj_back.
//
//  channel  | handshake        | fields
//  ---------+------------------+--------------------------
//  input    | push / full      | char_code
//  result   | empty / pop      | out_char, last, status
//
// One character is taken per cycle while the command queue has room.
// Each character turns into 0 to 6 output bytes; the back end sends one byte
// per cycle while pop keeps up, so the sustained rate is set by the output byte
// count, with four queued commands of slack.
// Reset is asynchronous: start of string, depth zero, queue and output empty.
// A pop held low stalls the back end; full rises only once the queue fills.
`default_nettype none
module nested_edge_list_to_json import nelj_pkg::*; #(
	parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_code,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_char,
	output logic            last,
	output logic [1:0]      status
);

	logic cq_full, enq, deq, head_v;
	cmd_t enq_data, head;

	nelj_front #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_code (char_code),
		.cq_full   (cq_full),
		.full      (full),
		.enq       (enq),
		.enq_data  (enq_data)
	);

	nelj_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_data (enq_data),
		.deq      (deq),
		.full     (cq_full),
		.head_v   (head_v),
		.head     (head)
	);

	nelj_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_v   (head_v),
		.head     (head),
		.deq      (deq),
		.empty    (empty),
		.pop      (pop),
		.out_char (out_char),
		.last     (last),
		.status   (status)
	);

endmodule
`default_nettype wire

>>> design/nelj_front.sv
// Front end: takes one character a cycle while the queue has room, runs the parse
// state and depth counter, and emits at most one command record per character. Uses nelj_pkg.
`default_nettype none
module nelj_front import nelj_pkg::*; #(
	parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int unsigned DW        = $clog2(MAX_DEPTH + 1)
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] char_code,
	input  wire logic       cq_full,
	output logic            full,
	output logic            enq,
	output cmd_t            enq_data
);

	ph_t           phase_q, ph_d;
	logic [DW-1:0] depth_q, dp_d;
	logic          acc;
	logic          c_alpha, c_alnum, c_sep, c_nul, c_lpar, c_rpar, at_max, dp_zero;
	ph_t           fin_ph;
	cmd_t          cmd;

	assign full    = cq_full;
	assign acc     = push && !cq_full;
	assign enq     = acc && (cmd.n != 3'd0);
	assign enq_data = cmd;

	assign c_alpha = is_alpha(char_code);
	assign c_alnum = c_alpha || is_digit(char_code);
	assign c_sep   = (char_code == CH_COMMA) || (char_code == CH_PIPE);
	assign c_nul   = (char_code == CH_NUL);
	assign c_lpar  = (char_code == CH_LPAR);
	assign c_rpar  = (char_code == CH_RPAR);
	assign at_max  = depth_q >= DW'(MAX_DEPTH);
	assign dp_zero = (depth_q == '0);
	assign fin_ph  = c_nul ? PH_START : PH_SKIP;

	// next state
	always_comb begin
		ph_d = phase_q;
		dp_d = depth_q;
		unique case (phase_q)
			PH_START, PH_EXPECT: begin
				if (c_alpha) begin
					ph_d = PH_KEY;
					if (phase_q == PH_START) dp_d = '0;
				end else begin
					ph_d = fin_ph;
					dp_d = '0;
				end
			end
			PH_KEY, PH_AFTER: begin
				if (phase_q == PH_KEY && c_alnum) begin
					ph_d = PH_KEY;
				end else if (phase_q == PH_KEY && c_lpar) begin
					if (at_max) begin
						ph_d = fin_ph;
						dp_d = '0;
					end else begin
						ph_d = PH_EXPECT;
						dp_d = depth_q + 1'b1;
					end
				end else if (c_sep) begin
					ph_d = PH_EXPECT;
				end else if (!dp_zero && c_rpar) begin
					ph_d = PH_AFTER;
					dp_d = depth_q - 1'b1;
				end else begin
					ph_d = fin_ph;
					dp_d = '0;
				end
			end
			PH_SKIP: begin
				if (c_nul) begin
					ph_d = PH_START;
					dp_d = '0;
				end
			end
			default: begin
				ph_d = PH_START;
				dp_d = '0;
			end
		endcase
	end

	// bytes to emit
	always_comb begin
		cmd = CMD_NONE;
		unique case (phase_q)
			PH_START, PH_EXPECT: begin
				if (phase_q == PH_START) begin
					cmd = cmd_add(cmd, CH_LBRACE);
					cmd = cmd_add(cmd, CH_QUOTE);
				end
				if (c_alpha) begin
					cmd = cmd_add(cmd, char_code);
				end else begin
					cmd = cmd_add(cmd, CH_RBRACE);
					cmd.fin = ST_REJ;
				end
			end
			PH_KEY, PH_AFTER: begin
				if (phase_q == PH_KEY && c_alnum) begin
					cmd = cmd_add(cmd, char_code);
				end else begin
					if (phase_q == PH_KEY) begin
						cmd = cmd_add(cmd, CH_QUOTE);
						cmd = cmd_add(cmd, CH_COLON);
					end
					if (phase_q == PH_KEY && c_lpar) begin
						if (at_max) begin
							cmd = cmd_add(cmd, CH_RBRACE);
							cmd.fin = ST_REJ;
						end else begin
							cmd = cmd_add(cmd, CH_LBRACE);
							cmd = cmd_add(cmd, CH_QUOTE);
						end
					end else begin
						if (phase_q == PH_KEY) begin
							cmd = cmd_add(cmd, CH_LBRACE);
							cmd = cmd_add(cmd, CH_RBRACE);
						end
						if (c_sep) begin
							cmd = cmd_add(cmd, CH_COMMA);
							cmd = cmd_add(cmd, CH_QUOTE);
						end else begin
							cmd = cmd_add(cmd, CH_RBRACE);
							if (dp_zero) cmd.fin = ST_ACC;
							else if (!c_rpar) cmd.fin = ST_REJ;
						end
					end
				end
			end
			PH_SKIP: cmd = CMD_NONE;
			default: cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			depth_q <= '0;
		end else if (acc) begin
			phase_q <= ph_d;
			depth_q <= dp_d;
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH)) else $error("depth beyond limit");
	a_skip_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP || phase_q == PH_START) |-> dp_zero)
		else $error("depth left open after verdict");
	a_verdict_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(enq && enq_data.fin != ST_RUN) |=> (phase_q == PH_SKIP || phase_q == PH_START))
		else $error("verdict without leaving the list");

endmodule
`default_nettype wire

>>> design/nelj_cmdq.sv
// Short command queue between front end and back end.
// Register-based, one write and one read a cycle. Uses nelj_pkg.
`default_nettype none
module nelj_cmdq import nelj_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic enq,
	input  wire cmd_t enq_data,
	input  wire logic deq,
	output logic      full,
	output logic      head_v,
	output cmd_t      head
);

	cmd_t             ent_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wp_q, rp_q;
	logic [CQ_AW:0]   cnt_q;

	assign full   = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign head_v = (cnt_q != '0);
	assign head   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq) ent_q[wp_q] <= enq_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) wp_q <= wp_q + 1'b1;
			if (deq) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (CQ_AW+1)'(enq) - (CQ_AW+1)'(deq);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !enq) else $error("write into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!head_v |-> !deq) else $error("read from empty queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0 && cnt_q != (CQ_AW+1)'(CQ_DEPTH)) |-> (wp_q != rp_q))
		else $error("pointers disagree with count");

endmodule
`default_nettype wire

>>> design/nelj_back.sv
// Back end: expands the head command into single bytes in the output register,
// one per cycle while that register is empty or being popped. Uses nelj_pkg.
`default_nettype none
module nelj_back import nelj_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_v,
	input  wire cmd_t  head,
	output logic       deq,
	output logic       empty,
	input  wire logic  pop,
	output logic [7:0] out_char,
	output logic       last,
	output logic [1:0] status
);

	logic [2:0] idx_q;
	logic       out_v_q;
	logic       load, fin_byte;
	logic [7:0] char_q;
	logic       last_q;
	st_t        st_q;

	assign load     = head_v && (!out_v_q || pop);
	assign fin_byte = (idx_q == head.n - 3'd1);
	assign deq      = load && fin_byte;
	assign empty    = !out_v_q;
	assign out_char = char_q;
	assign last     = last_q;
	assign status   = st_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.b[idx_q];
			last_q <= fin_byte && (head.fin != ST_RUN);
			st_q   <= fin_byte ? head.fin : ST_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) idx_q <= fin_byte ? 3'd0 : idx_q + 3'd1;
			if (load) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

	a_mid_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 3'd0) |-> head_v) else $error("command lost mid expansion");
	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		head_v |-> (idx_q < head.n)) else $error("byte index past command");
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && st_q != ST_RUN) |-> last_q) else $error("verdict off the last byte");

endmodule
`default_nettype wire
